// ----- hw/rtl/bsc_pkg.sv -----
// Shared types and constants of the byte-stuffing codec.
package bsc_pkg;

  localparam logic [7:0] ESC_BYTE = 8'h09;
  localparam logic [7:0] PAD_CODE = 8'h10;
  localparam logic [7:0] SOC_CODE = 8'h11;
  localparam logic [7:0] EOC_CODE = 8'h12;

  // configuration register indexes
  localparam logic [1:0] CFG_DIRECTION  = 2'd0;
  localparam logic [1:0] CFG_START_CODE = 2'd1;
  localparam logic [1:0] CFG_END_CODE   = 2'd2;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;
  localparam logic OP_DATA    = 1'b0;
  localparam logic OP_PAD     = 1'b1;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // one classified item: one result, or escape byte followed by byte1
  typedef struct packed {
    logic       pair;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       eop;
    logic       err;
  } bsc_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } bsc_qstat_t;

endpackage

// ----- hw/rtl/byte_stuffing_codec_unit.sv -----
// Top level of the byte-stuffing codec: front end, item queue and back end.
// Takes one input beat per cycle while the queue has room. A single-byte result passes through
// the queue and then the output register before it is presented. An escaped byte or pad
// marker needs two output bytes (0x09 then the code), so the single output register sets the
// output rate, and the four-entry queue absorbs bursts of expansions before in_tready drops.
// Decoder items that give no result (escape byte, pad code, dropped bytes) never enter the
// queue. Configuration writes take effect on the next accepted beat and must only be issued
// while the unit is idle.
module byte_stuffing_codec_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tuser,   // [0] operation
  input  logic       in_tlast,   // end_of_packet
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [1:0] out_tuser,  // [0] packet_end, [1] decode_error
  output logic       out_tlast   // last_of_run
);
  import bsc_pkg::*;

  bsc_entry_t q_entry, q_head;
  bsc_qstat_t q_stat;
  logic       q_push, q_pop;

  bsc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  bsc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .stat       (q_stat)
  );

  bsc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // error beat is a lone, final, zero byte
  a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast && out_tdata == 8'h00)
    else $error("error beat malformed");

  // packet end only on the final beat of an item
  a_pend_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("packet_end on non-final beat");

  // first beat of a pair is always the escape byte
  a_pair_esc: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata == ESC_BYTE)
    else $error("first beat of pair is not escape");

  // second beat of a pair follows straight away
  a_pair_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && out_tlast)
    else $error("second beat of pair missing");

  // queue never pushed while full
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("queue overrun");

endmodule

// ----- hw/rtl/bsc_front.sv -----
// Front end: configuration registers, input beat acceptance, encode/decode classification.
module bsc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_wdata,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  logic                in_tuser,
  input  logic                in_tlast,
  input  bsc_pkg::bsc_qstat_t q_stat,
  output logic                q_push,
  output bsc_pkg::bsc_entry_t q_entry
);
  import bsc_pkg::*;

  logic       dir_r;
  logic [7:0] start_r;
  logic [7:0] end_r;
  logic       esc_r, esc_nxt;
  logic       drop_r, drop_nxt;
  logic       emit;
  logic       acc;
  bsc_entry_t ent;

  assign in_tready = !q_stat.full;
  assign acc       = in_tvalid && in_tready;
  assign q_push    = acc && emit;
  assign q_entry   = ent;

  always_comb begin
    ent       = '0;
    ent.eop   = in_tlast;
    emit      = 1'b0;
    esc_nxt   = esc_r;
    drop_nxt  = drop_r;
    if (dir_r == DIR_ENCODE) begin
      emit      = 1'b1;
      ent.pair  = 1'b1;
      ent.byte0 = ESC_BYTE;
      if (in_tuser == OP_PAD) begin
        ent.byte1 = PAD_CODE;
      end else if (in_tdata == ESC_BYTE) begin
        ent.byte1 = ESC_BYTE;
      end else if (in_tdata == start_r) begin
        ent.byte1 = SOC_CODE;
      end else if (in_tdata == end_r) begin
        ent.byte1 = EOC_CODE;
      end else begin
        ent.pair  = 1'b0;
        ent.byte0 = in_tdata;
      end
    end else begin
      if (drop_r) begin
        emit = 1'b0;
      end else if (esc_r) begin
        esc_nxt = 1'b0;
        emit    = 1'b1;
        case (in_tdata)
          ESC_BYTE: ent.byte0 = ESC_BYTE;
          PAD_CODE: emit = 1'b0;
          SOC_CODE: ent.byte0 = start_r;
          EOC_CODE: ent.byte0 = end_r;
          default: begin
            ent.byte0 = 8'h00;
            ent.err   = 1'b1;
            drop_nxt  = 1'b1;
          end
        endcase
      end else if (in_tdata == ESC_BYTE) begin
        esc_nxt = 1'b1;
      end else begin
        emit      = 1'b1;
        ent.byte0 = in_tdata;
      end
      // packet end clears decoder state, a dangling escape is lost
      if (in_tlast) begin
        esc_nxt  = 1'b0;
        drop_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r   <= DIR_ENCODE;
      start_r <= 8'h02;
      end_r   <= 8'h03;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIRECTION:  dir_r   <= cfg_wdata[0];
        CFG_START_CODE: start_r <= cfg_wdata;
        CFG_END_CODE:   end_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r  <= 1'b0;
      drop_r <= 1'b0;
    end else if (acc) begin
      esc_r  <= esc_nxt;
      drop_r <= drop_nxt;
    end
  end

endmodule

// ----- hw/rtl/bsc_queue.sv -----
// Short queue of classified items between front and back end.
module bsc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  bsc_pkg::bsc_entry_t push_entry,
  input  logic                pop,
  output bsc_pkg::bsc_entry_t head,
  output bsc_pkg::bsc_qstat_t stat
);
  import bsc_pkg::*;

  bsc_entry_t           slot_r [QDEPTH];
  logic [QAW-1:0]       wp_r, rp_r;
  logic [QCW-1:0]       cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign stat.full  = (cnt_r == QCW'(QDEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = slot_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wp_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- hw/rtl/bsc_back.sv -----
// Back end: expands queued items into output beats through an output register.
module bsc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  bsc_pkg::bsc_entry_t head,
  input  bsc_pkg::bsc_qstat_t q_stat,
  output logic                q_pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,
  output logic [1:0]          out_tuser,
  output logic                out_tlast
);
  import bsc_pkg::*;

  logic       vld_r;
  logic [7:0] byte_r;
  logic       last_r;
  logic       pend_r;
  logic       err_r;
  logic       phase_r;   // second beat of an escape pair is due
  logic       load;

  assign load       = !q_stat.empty && (!vld_r || out_tready);
  assign q_pop      = load && (!head.pair || phase_r);
  assign out_tvalid = vld_r;
  assign out_tdata  = byte_r;
  assign out_tlast  = last_r;
  assign out_tuser  = {err_r, pend_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      if (load) begin
        vld_r   <= 1'b1;
        phase_r <= head.pair && !phase_r;
      end else if (out_tready) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (head.pair && !phase_r) begin
        byte_r <= head.byte0;
        last_r <= 1'b0;
        pend_r <= 1'b0;
        err_r  <= 1'b0;
      end else begin
        byte_r <= head.pair ? head.byte1 : head.byte0;
        last_r <= 1'b1;
        pend_r <= head.eop;
        err_r  <= head.err;
      end
    end
  end

endmodule

// ----- tb/sv/byte_stuffing_codec_unit_test.sv -----
// Self-checking testbench of the byte-stuffing codec: stuffing and unstuffing beats checked
// against a behavioural codec.
module byte_stuffing_codec_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bsc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 10;

  typedef struct {
    logic       op;
    logic [7:0] data;
    logic       eop;
  } link_item_t;

  typedef struct {
    logic [7:0] value;
    logic       last;
    logic       pkt_end;
    logic       err;
  } coded_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_DIRECTION;
  logic [7:0] cfg_wdata = 8'h00;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] data_byte
  logic       in_tuser = OP_DATA; // [0] operation
  logic       in_tlast = 1'b0;    // end_of_packet
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [7:0] out_byte
  logic [1:0] out_tuser;          // [0] packet_end, [1] decode_error
  logic       out_tlast;          // last_of_run

  byte_stuffing_codec_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  link_item_t  tx_items[$];
  link_item_t  beat_on_bus;
  coded_byte_t awaited_bytes[$];
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          failures = 0;
  int          cycle_count = 0;

  // register mirror and unstuffer state
  logic       mode_dir = DIR_ENCODE;
  logic [7:0] sof_code = 8'h02;
  logic [7:0] eof_code = 8'h03;
  logic       esc_seen = 1'b0;
  logic       discarding = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("byte_stuffing_codec_unit verification failed");
      $finish;
    end
  end

  task automatic await_byte(logic [7:0] value, logic last, logic eop, logic err);
    coded_byte_t r;
    r.value = value;
    r.last = last;
    r.pkt_end = last ? eop : 1'b0;
    r.err = err;
    awaited_bytes.push_back(r);
  endtask

  task automatic transcode_beat(link_item_t it);
    logic [7:0] code;
    logic       pair;
    pair = 1'b1;
    code = PAD_CODE;
    if (mode_dir == DIR_ENCODE) begin
      if (it.op == OP_PAD) code = PAD_CODE;
      else if (it.data == ESC_BYTE) code = ESC_BYTE;
      else if (it.data == sof_code) code = SOC_CODE;
      else if (it.data == eof_code) code = EOC_CODE;
      else pair = 1'b0;
      if (pair) begin
        await_byte(ESC_BYTE, 1'b0, it.eop, 1'b0);
        await_byte(code, 1'b1, it.eop, 1'b0);
      end else begin
        await_byte(it.data, 1'b1, it.eop, 1'b0);
      end
    end else begin
      // operation is ignored when unstuffing
      if (discarding) begin
      end else if (esc_seen) begin
        esc_seen = 1'b0;
        if (it.data == ESC_BYTE) await_byte(ESC_BYTE, 1'b1, it.eop, 1'b0);
        else if (it.data == PAD_CODE) begin
        end else if (it.data == SOC_CODE) await_byte(sof_code, 1'b1, it.eop, 1'b0);
        else if (it.data == EOC_CODE) await_byte(eof_code, 1'b1, it.eop, 1'b0);
        else begin
          await_byte(8'h00, 1'b1, it.eop, 1'b1);
          discarding = 1'b1;
        end
      end else if (it.data == ESC_BYTE) begin
        esc_seen = 1'b1;
      end else begin
        await_byte(it.data, 1'b1, it.eop, 1'b0);
      end
      if (it.eop) begin
        esc_seen = 1'b0;
        discarding = 1'b0;
      end
    end
  endtask

  // input side: hold a beat until taken, then maybe idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) transcode_beat(beat_on_bus);
      if (!in_tvalid || in_tready) begin
        if (tx_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          beat_on_bus = tx_items.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= beat_on_bus.data;
          in_tuser <= beat_on_bus.op;
          in_tlast <= beat_on_bus.eop;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endfunction

  // result side
  always @(posedge clk) begin
    coded_byte_t want;
    out_tready <= ($urandom_range(99) >= stall_pct);
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_bytes.size() == 0) begin
        $error("out_byte: expected nothing, got %0h", out_tdata);
        failures++;
      end else begin
        want = awaited_bytes.pop_front();
        check_field("out_byte", int'(want.value), int'(out_tdata));
        check_field("last_of_run", int'(want.last), int'(out_tlast));
        check_field("packet_end", int'(want.pkt_end), int'(out_tuser[0]));
        check_field("decode_error", int'(want.err), int'(out_tuser[1]));
      end
    end
  end

  task automatic add_item(logic op, logic [7:0] data, logic eop);
    link_item_t it;
    it.op = op;
    it.data = data;
    it.eop = eop;
    tx_items.push_back(it);
  endtask

  task automatic settle();
    do @(negedge clk);
    while (tx_items.size() != 0 || in_tvalid || awaited_bytes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_settings(logic dir, logic [7:0] sc, logic [7:0] ec);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_DIRECTION;
    cfg_wdata <= {7'd0, dir};
    @(posedge clk);
    cfg_index <= CFG_START_CODE;
    cfg_wdata <= sc;
    @(posedge clk);
    cfg_index <= CFG_END_CODE;
    cfg_wdata <= ec;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_dir = dir;
    sof_code = sc;
    eof_code = ec;
  endtask

  // raw bytes biased towards the ones that need stuffing
  task automatic gen_encode(int n);
    int r;
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 15) b = ESC_BYTE;
      else if (r < 30) b = sof_code;
      else if (r < 45) b = eof_code;
      else b = 8'($urandom_range(255));
      add_item(($urandom_range(9) == 0) ? OP_PAD : OP_DATA, b, $urandom_range(5) == 0);
    end
  endtask

  // mostly well-formed stuffed packets, some broken escapes and plain noise
  task automatic gen_decode(int n);
    int made;
    int len;
    int r;
    logic last;
    logic [7:0] code;
    made = 0;
    while (made < n) begin
      if ($urandom_range(9) == 0) begin
        add_item(1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)));
        made++;
      end else begin
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
          last = (k == len - 1);
          r = $urandom_range(99);
          if (r < 45) begin
            add_item(1'($urandom_range(1)), 8'($urandom_range(255)), last);
            made++;
          end else if (r < 88) begin
            case ($urandom_range(3))
              0: code = ESC_BYTE;
              1: code = PAD_CODE;
              2: code = SOC_CODE;
              default: code = EOC_CODE;
            endcase
            add_item(1'($urandom_range(1)), ESC_BYTE, 1'b0);
            add_item(1'($urandom_range(1)), code, last);
            made += 2;
          end else if (r < 95) begin
            add_item(1'($urandom_range(1)), ESC_BYTE, 1'b0);
            add_item(1'($urandom_range(1)), 8'($urandom_range(255)), last);
            made += 2;
          end else begin
            add_item(1'($urandom_range(1)), ESC_BYTE, last);
            made++;
          end
        end
      end
    end
  endtask

  initial begin
    logic       ph_dir[8]  = '{DIR_ENCODE, DIR_DECODE, DIR_ENCODE, DIR_DECODE,
                               DIR_ENCODE, DIR_DECODE, DIR_ENCODE, DIR_DECODE};
    logic [7:0] ph_sc[8]   = '{8'h02, 8'h02, 8'h00, 8'hFF, 8'h09, 8'h11, 8'h7F, 8'h09};
    logic [7:0] ph_ec[8]   = '{8'h03, 8'h03, 8'hFF, 8'h00, 8'h09, 8'h12, 8'h7F, 8'hFF};
    int         ph_send[8] = '{0, 80, 0, 37, 37, 0, 80, 0};
    int         ph_stall[8] = '{0, 0, 80, 37, 37, 0, 0, 80};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // stuffing at reset settings: extremes, each escaped byte, pad
    add_item(OP_DATA, 8'h00, 1'b0);
    add_item(OP_DATA, 8'hFF, 1'b0);
    add_item(OP_DATA, ESC_BYTE, 1'b0);
    add_item(OP_DATA, 8'h02, 1'b0);
    add_item(OP_DATA, 8'h03, 1'b1);
    add_item(OP_PAD, 8'hAA, 1'b1);
    add_item(OP_DATA, 8'h10, 1'b1);
    settle();

    // unstuffing: every escape, bad escape then discard, dangling escape
    write_settings(DIR_DECODE, 8'h02, 8'h03);
    add_item(OP_DATA, ESC_BYTE, 1'b0);
    add_item(OP_DATA, ESC_BYTE, 1'b0);
    add_item(OP_DATA, ESC_BYTE, 1'b0);
    add_item(OP_DATA, PAD_CODE, 1'b0);
    add_item(OP_DATA, ESC_BYTE, 1'b0);
    add_item(OP_DATA, SOC_CODE, 1'b0);
    add_item(OP_DATA, ESC_BYTE, 1'b0);
    add_item(OP_DATA, EOC_CODE, 1'b1);
    add_item(OP_DATA, ESC_BYTE, 1'b0);
    add_item(OP_DATA, 8'h55, 1'b0);
    add_item(OP_DATA, 8'h41, 1'b0);
    add_item(OP_DATA, 8'h42, 1'b1);
    add_item(OP_PAD, 8'h33, 1'b0);
    add_item(OP_DATA, ESC_BYTE, 1'b1);
    add_item(OP_DATA, ESC_BYTE, 1'b0);
    add_item(OP_DATA, 8'h13, 1'b1);
    add_item(OP_PAD, 8'hFF, 1'b1);
    // escape left open across a switch to stuffing and back
    add_item(OP_DATA, ESC_BYTE, 1'b0);
    settle();

    for (int p = 0; p < 8; p++) begin
      send_idle_pct = ph_send[p];
      stall_pct = ph_stall[p];
      write_settings(ph_dir[p], ph_sc[p], ph_ec[p]);
      if (ph_dir[p] == DIR_ENCODE) gen_encode(110);
      else gen_decode(110);
      settle();
    end

    if (failures == 0) begin
      $display("byte_stuffing_codec_unit verification clean");
    end else begin
      $display("byte_stuffing_codec_unit verification failed");
    end
    $finish;
  end

endmodule
